### hdl/assert_macros.svh
// assertion macros used by the tracker unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");

`endif

### hdl/rvtt_pkg.sv
// types and constants of the rectangle visibility threshold tracker
package rvtt_pkg;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int AREA_W      = 46;
    localparam int RATIO_W     = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROOT_LEFT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROOT_TOP    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROOT_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROOT_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_THR_COUNT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_THR_LOW     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_THR_HIGH    = 3'd6;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FORGET = 1'b1;

    localparam logic [RATIO_W-1:0] RATIO_ONE      = 16'h8000;
    localparam logic [3:0]         NEVER_REPORTED = 4'd15;

    typedef struct packed {
        logic               command;
        logic [5:0]         target_slot;
        logic               target_measurable;
        logic [31:0]        frame_time;
        logic signed [23:0] target_left;
        logic signed [23:0] target_top;
        logic [22:0]        target_width;
        logic [22:0]        target_height;
    } t_sample;

    typedef struct packed {
        logic [5:0]         report_slot;
        logic [31:0]        report_time;
        logic [3:0]         crossing_index;
        logic               is_intersecting;
        logic [15:0]        visible_ratio;
        logic signed [23:0] overlap_left;
        logic signed [23:0] overlap_top;
        logic [22:0]        overlap_width;
        logic [22:0]        overlap_height;
    } t_report;

    typedef struct packed {
        logic [3:0] index;
        logic       intersecting;
    } t_entry;

    localparam t_entry ENTRY_NEVER = '{index: NEVER_REPORTED, intersecting: 1'b0};

endpackage

### hdl/rvtt_sample_if.sv
// sample channel: valid, ready and one target sample
interface rvtt_sample_if
    import rvtt_pkg::*;
();
    logic    valid;
    logic    ready;
    t_sample payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### hdl/rvtt_report_if.sv
// report channel: valid, ready and one visibility record
interface rvtt_report_if
    import rvtt_pkg::*;
();
    logic    valid;
    logic    ready;
    t_report payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### hdl/rect_visibility_threshold_tracker_unit.sv
// Rectangle visibility threshold tracker. One item is taken at a time: a forget
// or an out-of-range slot finishes in the cycle it is taken; a sample steps
// through the edge, clip, ratio and decide states, the ratio state only with a
// target area, where the shared 23x23 multiplier (two products) and the 16-step
// restoring divider form the Q1.15 ratio. A record waits in an output register,
// and the table commit waits for it to be free. After reset the slot table is
// cleared one entry a cycle, during which no sample is taken; configuration
// writes are taken at any time the block is idle.
module rect_visibility_threshold_tracker_unit
    import rvtt_pkg::*;
#(
    parameter int MAX_TARGETS     = 64,
    parameter int MAX_THRESHOLDS  = 8,
    parameter int COORD_FRAC_BITS = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    rvtt_sample_if.sink            i_sample,
    rvtt_report_if.source          o_report
);
`include "assert_macros.svh"

    localparam int          AW        = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam logic [22:0] PIXEL_ONE = 23'(1 << COORD_FRAC_BITS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EDGE   = 3'd1;
    localparam logic [2:0] S_CLIP   = 3'd2;
    localparam logic [2:0] S_RATIO  = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;

    logic signed [23:0] r_root_left, r_root_top;
    logic [22:0]        r_root_width, r_root_height;
    logic [3:0]         r_thr_count;
    logic [63:0]        r_thr_low, r_thr_high;

    logic [2:0]         r_state;
    t_sample            r_item;
    logic signed [24:0] r_l, r_t, r_r, r_b;
    logic signed [23:0] r_ol, r_ot;
    logic [22:0]        r_ow, r_oh;
    logic               r_hit;
    logic [15:0]        r_ratio;
    logic               r_out_valid;
    t_report            r_out;

    logic               w_accept, w_clearing, w_slot_ok, w_out_free;
    logic [AW-1:0]      w_slot_addr, w_item_addr;
    logic signed [24:0] w_tl, w_tt, w_rl, w_rt, w_tr, w_tb, w_rr, w_rb;
    logic signed [24:0] w_ow, w_oh;
    logic               w_none, w_hit, w_widen, w_area_ok;
    logic [22:0]        w_tw, w_th;
    logic               w_ratio_start, w_div_done;
    logic [15:0]        w_quot;
    logic [3:0]         w_cnt, w_idx;
    logic [127:0]       w_thr_all;
    logic               w_changed, w_commit;
    t_entry             w_rd_entry, w_wr_entry;
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    logic               w_miss_ok;

    assign w_accept    = i_sample.valid && i_sample.ready;
    assign i_sample.ready = (r_state == S_IDLE) && !w_clearing;
    assign w_slot_ok   = 13'(i_sample.payload.target_slot) < 13'(MAX_TARGETS);
    assign w_slot_addr = AW'(13'(i_sample.payload.target_slot));
    assign w_item_addr = AW'(13'(r_item.target_slot));
    assign w_out_free  = !r_out_valid || o_report.ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_left   <= '0;
            r_root_top    <= '0;
            r_root_width  <= '0;
            r_root_height <= '0;
            r_thr_count   <= 4'd1;
            r_thr_low     <= '0;
            r_thr_high    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROOT_LEFT:   r_root_left   <= i_cfg_data[23:0];
                CFG_ROOT_TOP:    r_root_top    <= i_cfg_data[23:0];
                CFG_ROOT_WIDTH:  r_root_width  <= i_cfg_data[22:0];
                CFG_ROOT_HEIGHT: r_root_height <= i_cfg_data[22:0];
                CFG_THR_COUNT:   r_thr_count   <= i_cfg_data[3:0];
                CFG_THR_LOW:     r_thr_low     <= i_cfg_data;
                CFG_THR_HIGH:    r_thr_high    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // edge geometry
    assign w_tl = {r_item.target_left[23], r_item.target_left};
    assign w_tt = {r_item.target_top[23], r_item.target_top};
    assign w_rl = {r_root_left[23], r_root_left};
    assign w_rt = {r_root_top[23], r_root_top};
    assign w_tr = w_tl + $signed({2'b00, r_item.target_width});
    assign w_tb = w_tt + $signed({2'b00, r_item.target_height});
    assign w_rr = w_rl + $signed({2'b00, r_root_width});
    assign w_rb = w_rt + $signed({2'b00, r_root_height});

    // clipping
    assign w_tw      = r_item.target_measurable ? r_item.target_width  : '0;
    assign w_th      = r_item.target_measurable ? r_item.target_height : '0;
    assign w_ow      = r_r - r_l;
    assign w_oh      = r_b - r_t;
    assign w_none    = !r_item.target_measurable || (r_r < r_l) || (r_b < r_t);
    assign w_hit     = !w_none && ((w_ow != 0) || (w_tw == '0))
                               && ((w_oh != 0) || (w_th == '0));
    assign w_widen   = w_hit && (w_oh == 0);
    assign w_area_ok = (w_tw != '0) && (w_th != '0);
    assign w_ratio_start = (r_state == S_CLIP) && w_area_ok;

    rvtt_ratio_unit u_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ratio_start),
        .i_tw    (w_tw),
        .i_th    (w_th),
        .i_ow    (r_ow),
        .i_oh    (r_oh),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // first threshold above the ratio, the count if none is, zero on a miss
    assign w_thr_all = {r_thr_high, r_thr_low};
    always_comb begin
        logic [15:0] v_thr;
        if (r_thr_count == 4'd0) begin
            w_cnt = 4'd1;
        end else if (r_thr_count > 4'(MAX_THRESHOLDS)) begin
            w_cnt = 4'(MAX_THRESHOLDS);
        end else begin
            w_cnt = r_thr_count;
        end
        w_idx = w_cnt;
        for (int i = MAX_THRESHOLDS - 1; i >= 0; i--) begin
            v_thr = w_thr_all[16*i +: 16];
            if (v_thr > RATIO_ONE) begin
                v_thr = RATIO_ONE;
            end
            if ((4'(i) < w_cnt) && (v_thr > r_ratio)) begin
                w_idx = 4'(i);
            end
        end
        if (!r_hit) begin
            w_idx = 4'd0;
        end
    end

    assign w_changed = (w_idx != w_rd_entry.index) || (r_hit != w_rd_entry.intersecting);
    assign w_commit  = (r_state == S_DECIDE) && w_changed && w_out_free;

    // slot table
    always_comb begin
        w_wr_en    = 1'b0;
        w_wr_addr  = w_item_addr;
        w_wr_entry = '{index: w_idx, intersecting: r_hit};
        if (w_accept && (i_sample.payload.command == CMD_FORGET) && w_slot_ok) begin
            w_wr_en    = 1'b1;
            w_wr_addr  = w_slot_addr;
            w_wr_entry = ENTRY_NEVER;
        end else if (w_commit) begin
            w_wr_en = 1'b1;
        end
    end

    rvtt_state_table #(
        .MAX_TARGETS (MAX_TARGETS),
        .AW          (AW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_accept),
        .i_rd_addr  (w_slot_addr),
        .o_rd_data  (w_rd_entry),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (w_wr_addr),
        .i_wr_data  (w_wr_entry),
        .o_clearing (w_clearing)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_sample.payload.command == CMD_SAMPLE) && w_slot_ok) begin
                        r_state <= S_EDGE;
                    end
                end
                S_EDGE: r_state <= S_CLIP;
                S_CLIP: r_state <= w_area_ok ? S_RATIO : S_DECIDE;
                S_RATIO: begin
                    if (w_div_done) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (!w_changed || w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_sample.payload;
        end
        if (r_state == S_EDGE) begin
            r_l <= (w_tl > w_rl) ? w_tl : w_rl;
            r_t <= (w_tt > w_rt) ? w_tt : w_rt;
            r_r <= (w_tr < w_rr) ? w_tr : w_rr;
            r_b <= (w_tb < w_rb) ? w_tb : w_rb;
        end
        if (r_state == S_CLIP) begin
            r_hit <= w_hit;
            if (w_none) begin
                r_ol <= '0;
                r_ot <= '0;
                r_ow <= '0;
                r_oh <= '0;
            end else begin
                r_ol <= r_l[23:0];
                r_ot <= r_t[23:0];
                r_ow <= (w_widen && (w_ow == 0)) ? PIXEL_ONE : w_ow[22:0];
                r_oh <= w_widen ? PIXEL_ONE : w_oh[22:0];
            end
            r_ratio <= w_hit ? RATIO_ONE : '0;
        end
        if ((r_state == S_RATIO) && w_div_done) begin
            r_ratio <= (w_quot > RATIO_ONE) ? RATIO_ONE : w_quot;
        end
        if (w_commit) begin
            r_out.report_slot     <= r_item.target_slot;
            r_out.report_time     <= r_item.frame_time;
            r_out.crossing_index  <= w_idx;
            r_out.is_intersecting <= r_hit;
            r_out.visible_ratio   <= r_ratio;
            r_out.overlap_left    <= r_ol;
            r_out.overlap_top     <= r_ot;
            r_out.overlap_width   <= r_ow;
            r_out.overlap_height  <= r_oh;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (o_report.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_report.valid   = r_out_valid;
    assign o_report.payload = r_out;

    assign w_miss_ok = (r_out.crossing_index == 4'd0) && (r_out.visible_ratio == 16'd0);

    `ASSERT_CLK(a_accept_idle, i_clk, i_rst_n, w_accept |-> (r_state == S_IDLE && !w_clearing))
    `ASSERT_CLK(a_miss_zero, i_clk, i_rst_n, (r_out_valid && !r_out.is_intersecting) |-> w_miss_ok)
    `ASSERT_NEVER(a_div_stray, i_clk, i_rst_n, w_div_done && (r_state != S_RATIO))
endmodule

### hdl/rvtt_ratio_unit.sv
// shared multiplier and restoring divider for the visible area ratio
module rvtt_ratio_unit
    import rvtt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [22:0]        i_tw,
    input  logic [22:0]        i_th,
    input  logic [22:0]        i_ow,
    input  logic [22:0]        i_oh,
    output logic               o_done,
    output logic [RATIO_W-1:0] o_quot
);
    localparam logic [1:0] U_IDLE  = 2'd0;
    localparam logic [1:0] U_MUL_A = 2'd1;
    localparam logic [1:0] U_MUL_B = 2'd2;
    localparam logic [1:0] U_DIV   = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [AREA_W-1:0]  r_ta, n_ta;
    logic [AREA_W-1:0]  r_rem, n_rem;
    logic [RATIO_W-1:0] r_q, n_q;
    logic [3:0]         r_cnt, n_cnt;
    logic               r_done, n_done;

    logic [22:0]       w_mul_a, w_mul_b;
    logic [AREA_W-1:0] w_prod;
    logic [AREA_W:0]   w_shift, w_diff;

    assign w_mul_a = (r_state == U_MUL_A) ? i_tw : i_ow;
    assign w_mul_b = (r_state == U_MUL_A) ? i_th : i_oh;
    assign w_prod  = w_mul_a * w_mul_b;
    assign w_shift = (r_cnt == 4'd0) ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign w_diff  = w_shift - {1'b0, r_ta};

    always_comb begin
        n_state = r_state;
        n_ta    = r_ta;
        n_rem   = r_rem;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        case (r_state)
            U_IDLE: begin
                if (i_start) begin
                    n_state = U_MUL_A;
                end
            end
            U_MUL_A: begin
                n_ta    = w_prod;
                n_state = U_MUL_B;
            end
            U_MUL_B: begin
                n_rem   = w_prod;
                n_cnt   = 4'd0;
                n_q     = '0;
                n_state = U_DIV;
            end
            U_DIV: begin
                if (!w_diff[AREA_W]) begin
                    n_rem = w_diff[AREA_W-1:0];
                    n_q   = {r_q[RATIO_W-2:0], 1'b1};
                end else begin
                    n_rem = w_shift[AREA_W-1:0];
                    n_q   = {r_q[RATIO_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_done  = 1'b1;
                    n_state = U_IDLE;
                end
            end
            default: n_state = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
        r_ta  <= n_ta;
        r_rem <= n_rem;
        r_q   <= n_q;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

### hdl/rvtt_state_table.sv
// per-slot memory of last reported index and flag, cleared after reset
module rvtt_state_table
    import rvtt_pkg::*;
#(
    parameter int MAX_TARGETS = 64,
    parameter int AW          = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    output logic          o_clearing
);
    t_entry        r_mem [MAX_TARGETS];
    t_entry        r_rd_data;
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(MAX_TARGETS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= ENTRY_NEVER;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;
endmodule

### tb/sv/testbench.sv
// testbench of the rectangle visibility threshold tracker: directed table, random phases
`timescale 1ns / 100ps

module testbench;
    import rvtt_pkg::*;

    typedef enum int {ROW_PREDICT, ROW_RECORD, ROW_SILENT} t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_sample   sample;
        t_report   record;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    rvtt_sample_if sample_ch();
    rvtt_report_if report_ch();

    rect_visibility_threshold_tracker_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (sample_ch.sink),
        .o_report    (report_ch.source)
    );

    // tracker copy of the block's state and registers
    longint      root_l, root_t, root_w, root_h;
    logic [3:0]  thr_count;
    logic [63:0] thr_low, thr_high;
    logic [3:0]  last_index [64];
    logic        last_hit [64];

    t_report pending_records[$];
    int      errors;
    bit      quiet;
    bit      hold_req;
    bit      hold_done;
    int      hold_cnt;
    int      stall_left;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #50ms;
        $display("testbench: FAIL");
        $finish;
    end

    task automatic mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic longint unsigned thr_at(input int i);
        logic [63:0] w;
        longint unsigned t;
        w = (i < 4) ? thr_low : thr_high;
        t = (w >> ((i % 4) * 16)) & 64'hFFFF;
        return (t > 32768) ? 32768 : t;
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] v);
        case (idx)
            CFG_ROOT_LEFT:   root_l = longint'($signed(v[23:0]));
            CFG_ROOT_TOP:    root_t = longint'($signed(v[23:0]));
            CFG_ROOT_WIDTH:  root_w = longint'(v[22:0]);
            CFG_ROOT_HEIGHT: root_h = longint'(v[22:0]);
            CFG_THR_COUNT:   thr_count = v[3:0];
            CFG_THR_LOW:     thr_low = v;
            CFG_THR_HIGH:    thr_high = v;
            default: ;
        endcase
    endfunction

    // visibility of one target and the change against the slot table
    function automatic bit track_visibility(input t_sample s, output t_report r);
        longint tl, tt, tw, th, l, t, rr, b, ol, ot, ow, oh;
        longint unsigned ta, oa, q, ratio;
        bit hit;
        int n, idx;
        ol = 0; ot = 0; ow = 0; oh = 0; tw = 0; th = 0;
        hit = 1'b0;
        r = '0;
        if (s.command == CMD_FORGET) begin
            last_index[s.target_slot] = NEVER_REPORTED;
            last_hit[s.target_slot] = 1'b0;
            return 1'b0;
        end
        if (s.target_measurable) begin
            tl = longint'($signed(s.target_left));
            tt = longint'($signed(s.target_top));
            tw = longint'(s.target_width);
            th = longint'(s.target_height);
            l = (tl > root_l) ? tl : root_l;
            t = (tt > root_t) ? tt : root_t;
            rr = ((tl + tw) < (root_l + root_w)) ? (tl + tw) : (root_l + root_w);
            b = ((tt + th) < (root_t + root_h)) ? (tt + th) : (root_t + root_h);
            if (!(rr < l || b < t)) begin
                ol = l;
                ot = t;
                ow = rr - l;
                oh = b - t;
                hit = (ow > 0 || tw == 0) && (oh > 0 || th == 0);
                if (hit && oh <= 0) begin
                    oh = 16;
                    if (ow <= 0) ow = 16;
                end
            end
        end
        if (tw > 0 && th > 0) begin
            ta = tw * th;
            oa = ow * oh;
            q = (oa << 15) / ta;
            ratio = (q > 32768) ? 32768 : q;
        end else begin
            ratio = hit ? 32768 : 0;
        end
        idx = 0;
        if (hit) begin
            n = (thr_count == 4'd0) ? 1 : ((thr_count > 4'd8) ? 8 : int'(thr_count));
            idx = n;
            for (int i = n - 1; i >= 0; i--)
                if (thr_at(i) > ratio) idx = i;
        end
        if (idx == int'(last_index[s.target_slot]) && hit == last_hit[s.target_slot])
            return 1'b0;
        last_index[s.target_slot] = 4'(idx);
        last_hit[s.target_slot] = hit;
        r.report_slot = s.target_slot;
        r.report_time = s.frame_time;
        r.crossing_index = 4'(idx);
        r.is_intersecting = hit;
        r.visible_ratio = ratio[15:0];
        r.overlap_left = ol[23:0];
        r.overlap_top = ot[23:0];
        r.overlap_width = ow[22:0];
        r.overlap_height = oh[22:0];
        return 1'b1;
    endfunction

    function automatic t_sample mk(input logic cmd, input int slot, input logic meas,
                                   input logic [31:0] ft, input int l, input int t,
                                   input int w, input int h);
        t_sample s;
        s.command = cmd;
        s.target_slot = 6'(slot);
        s.target_measurable = meas;
        s.frame_time = ft;
        s.target_left = 24'(l);
        s.target_top = 24'(t);
        s.target_width = 23'(w);
        s.target_height = 23'(h);
        return s;
    endfunction

    function automatic int gap_len();
        if (quiet || $urandom_range(0, 99) < 60) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        apply_reg(idx, v);
        @(posedge i_clk);
    endtask

    task automatic write_all(input longint l, input longint t, input longint w, input longint h,
                             input logic [3:0] cnt, input logic [63:0] lo, input logic [63:0] hi);
        write_reg(CFG_ROOT_LEFT, l);
        write_reg(CFG_ROOT_TOP, t);
        write_reg(CFG_ROOT_WIDTH, w);
        write_reg(CFG_ROOT_HEIGHT, h);
        write_reg(CFG_THR_COUNT, 64'(cnt));
        write_reg(CFG_THR_LOW, lo);
        write_reg(CFG_THR_HIGH, hi);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // one transfer on the sample channel, then the expectation
    task automatic send(input t_sample s, input t_row_kind kind, input t_report typed);
        t_report r;
        int g;
        sample_ch.valid <= 1'b1;
        sample_ch.payload <= s;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
        if (track_visibility(s, r) && kind == ROW_PREDICT) pending_records = {pending_records, r};
        if (kind == ROW_RECORD) pending_records = {pending_records, typed};
        g = gap_len();
        if (g > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        int n;
        n = 0;
        sample_ch.valid <= 1'b0;
        while (pending_records.size() != 0 && n < 200000) begin
            @(posedge i_clk);
            n++;
        end
        if (pending_records.size() != 0)
            mismatch("records outstanding", 64'(pending_records.size()), 64'd0);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic t_sample random_sample();
        t_sample s;
        logic [159:0] v;
        longint span_w, span_h;
        v = {$urandom, $urandom, $urandom, $urandom, $urandom};
        s = v[133:0];
        s.command = ($urandom_range(0, 99) < 8) ? CMD_FORGET : CMD_SAMPLE;
        if ($urandom_range(0, 99) < 70) s.target_slot = 6'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < 90) s.target_measurable = 1'b1;
        if ($urandom_range(0, 99) < 75) begin
            span_w = root_w + 64;
            span_h = root_h + 64;
            s.target_width = ($urandom_range(0, 9) == 0) ? '0 :
                23'(clamp(longint'($urandom_range(0, 2 * int'(clamp(span_w, 0, 1 << 20)))),
                          0, 8388607));
            s.target_height = ($urandom_range(0, 9) == 0) ? '0 :
                23'(clamp(longint'($urandom_range(0, 2 * int'(clamp(span_h, 0, 1 << 20)))),
                          0, 8388607));
            s.target_left = 24'(clamp(root_l - longint'(s.target_width)
                + longint'($urandom_range(0,
                int'(clamp(span_w + longint'(s.target_width), 0, 1 << 21)))),
                -8388608, 8388607));
            s.target_top = 24'(clamp(root_t - longint'(s.target_height)
                + longint'($urandom_range(0,
                int'(clamp(span_h + longint'(s.target_height), 0, 1 << 21)))),
                -8388608, 8388607));
        end
        return s;
    endfunction

    function automatic logic [63:0] sorted_thresholds(input bit upper);
        logic [63:0] w;
        int base;
        base = upper ? 16384 : 0;
        for (int i = 0; i < 4; i++)
            w[i*16 +: 16] = 16'(base + i * 4096 + int'($urandom_range(0, 4095)));
        return w;
    endfunction

    // report channel: check each transfer, then pick ready for the next cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            report_ch.ready <= 1'b0;
            hold_cnt <= 0;
            hold_done <= 1'b0;
            stall_left <= 0;
        end else begin
            if (report_ch.valid && report_ch.ready) begin
                if (pending_records.size() == 0) begin
                    mismatch("unexpected record slot", 64'(report_ch.payload.report_slot),
                             64'd0);
                end else begin
                    t_report got, want;
                    got = report_ch.payload;
                    want = pending_records.pop_front();
                    if (got.report_slot != want.report_slot)
                        mismatch("report_slot", 64'(got.report_slot), 64'(want.report_slot));
                    if (got.report_time != want.report_time)
                        mismatch("report_time", 64'(got.report_time), 64'(want.report_time));
                    if (got.crossing_index != want.crossing_index)
                        mismatch("crossing_index", 64'(got.crossing_index),
                                 64'(want.crossing_index));
                    if (got.is_intersecting != want.is_intersecting)
                        mismatch("is_intersecting", 64'(got.is_intersecting),
                                 64'(want.is_intersecting));
                    if (got.visible_ratio != want.visible_ratio)
                        mismatch("visible_ratio", 64'(got.visible_ratio),
                                 64'(want.visible_ratio));
                    if (got.overlap_left != want.overlap_left)
                        mismatch("overlap_left", 64'(got.overlap_left),
                                 64'(want.overlap_left));
                    if (got.overlap_top != want.overlap_top)
                        mismatch("overlap_top", 64'(got.overlap_top), 64'(want.overlap_top));
                    if (got.overlap_width != want.overlap_width)
                        mismatch("overlap_width", 64'(got.overlap_width),
                                 64'(want.overlap_width));
                    if (got.overlap_height != want.overlap_height)
                        mismatch("overlap_height", 64'(got.overlap_height),
                                 64'(want.overlap_height));
                end
            end
            if (hold_req && !hold_done) begin
                report_ch.ready <= 1'b0;
                if (hold_cnt == 400) hold_done <= 1'b1;
                hold_cnt <= hold_cnt + 1;
            end else if (stall_left > 0) begin
                report_ch.ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (!quiet && $urandom_range(0, 99) < 25) begin
                report_ch.ready <= 1'b0;
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 2);
            end else begin
                report_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        t_row rows[$];
        t_row row;
        t_report none;
        t_sample s;
        logic [63:0] lo, hi;
        errors = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        none = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.payload = '0;
        root_l = 0; root_t = 0; root_w = 0; root_h = 0;
        thr_count = 4'd1; thr_low = '0; thr_high = '0;
        for (int i = 0; i < 64; i++) begin
            last_index[i] = NEVER_REPORTED;
            last_hit[i] = 1'b0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset state: a first sample always reports, a repeat does not, a forget is silent
        row.record = none;
        row.record.report_time = 32'h1234;
        row.kind = ROW_RECORD;
        row.sample = mk(CMD_SAMPLE, 0, 1'b0, 32'h1234, 0, 0, 0, 0);
        rows = {rows, row};
        row.kind = ROW_SILENT;
        row.sample = mk(CMD_SAMPLE, 0, 1'b0, 32'h99, 5, 5, 5, 5);
        rows = {rows, row};
        row.sample = mk(CMD_FORGET, 0, 1'b0, 32'h0, 0, 0, 0, 0);
        rows = {rows, row};
        foreach (rows[i]) send(rows[i].sample, rows[i].kind, rows[i].record);
        drain();
        rows.delete();

        write_all(0, 0, 1600, 1600, 4'd4, 64'h8000_4000_2000_0000, 64'h0);
        row.kind = ROW_PREDICT;
        row.record = none;
        // inside, quarter, touching edge, zero-size, zero height, outside, not measurable, extremes, repeats, forget
        row.sample = mk(CMD_SAMPLE, 1, 1'b1, 32'h0, 160, 160, 320, 320); rows = {rows, row};
        row.sample = mk(CMD_SAMPLE, 2, 1'b1, 32'hFFFFFFFF, -160, -160, 320, 320);
        rows = {rows, row};
        row.sample = mk(CMD_SAMPLE, 3, 1'b1, 32'h3, 1600, 0, 160, 160); rows = {rows, row};
        row.sample = mk(CMD_SAMPLE, 4, 1'b1, 32'h4, 800, 800, 0, 0); rows = {rows, row};
        row.sample = mk(CMD_SAMPLE, 5, 1'b1, 32'h5, 100, 1600, 320, 0); rows = {rows, row};
        row.sample = mk(CMD_SAMPLE, 6, 1'b1, 32'h6, 3200, 3200, 16, 16); rows = {rows, row};
        row.sample = mk(CMD_SAMPLE, 7, 1'b0, 32'h7, 160, 160, 320, 320); rows = {rows, row};
        row.sample = mk(CMD_SAMPLE, 8, 1'b1, 32'h8, -8388608, -8388608, 8388607, 8388607);
        rows = {rows, row};
        row.sample = mk(CMD_SAMPLE, 9, 1'b1, 32'h9, 8388607, 8388607, 8388607, 8388607);
        rows = {rows, row};
        row.sample = mk(CMD_SAMPLE, 63, 1'b1, 32'hA, -8388608, 8388607, 0, 0);
        rows = {rows, row};
        row.sample = mk(CMD_SAMPLE, 1, 1'b1, 32'hB, 1500, 160, 320, 320); rows = {rows, row};
        row.sample = mk(CMD_SAMPLE, 1, 1'b1, 32'hC, 1500, 160, 320, 320); rows = {rows, row};
        row.sample = mk(CMD_FORGET, 1, 1'b1, 32'hD, 0, 0, 0, 0); rows = {rows, row};
        row.sample = mk(CMD_SAMPLE, 1, 1'b1, 32'hE, 1500, 160, 320, 320); rows = {rows, row};
        row.sample = mk(CMD_SAMPLE, 3, 1'b1, 32'hF, 0, 1600, 1600, 16); rows = {rows, row};
        foreach (rows[i]) send(rows[i].sample, rows[i].kind, rows[i].record);
        drain();

        // unsorted thresholds, thresholds above one, count zero, count above eight
        write_all(-400, 400, 800, 800, 4'd15, 64'hFFFF_0100_6000_2000, 64'hC000_9000_8001_7000);
        foreach (rows[i]) send(rows[i].sample, ROW_PREDICT, none);
        drain();
        write_all(0, 0, 1600, 1600, 4'd0, 64'h0000_0000_0000_4000, 64'hFFFF_FFFF_FFFF_FFFF);
        foreach (rows[i]) send(rows[i].sample, ROW_PREDICT, none);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            quiet = (phase == 2);
            lo = sorted_thresholds(1'b0);
            hi = sorted_thresholds(1'b1);
            if (phase == 4) begin
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
            end
            case (phase)
                0: write_all(-8388608, -8388608, 8388607, 8388607, 4'd8, lo, hi);
                1: write_all(8388607, 8388607, 0, 0, 4'd1, lo, hi);
                default: write_all(longint'($urandom_range(0, 16777215)) - 8388608,
                                   longint'($urandom_range(0, 16777215)) - 8388608,
                                   longint'($urandom_range(0, 8000)),
                                   longint'($urandom_range(0, 8000)),
                                   4'($urandom_range(0, 15)), lo, hi);
            endcase
            if (phase == 3) hold_req = 1'b1;
            for (int k = 0; k < 75; k++) begin
                s = random_sample();
                send(s, ROW_PREDICT, none);
            end
            drain();
        end

        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
